>>> hdl/adaptive_impulse_noise_blanker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive impulse noise blanker
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_IMPULSE_NOISE_BLANKER_DEFINES_SVH
`define ADAPTIVE_IMPULSE_NOISE_BLANKER_DEFINES_SVH

// check cons in the same cycle as ante
`define AINB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ainb check failed");

// check cons in the cycle after ante
`define AINB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ainb check failed");

`endif

>>> hdl/ainb_pkg.sv
// ----------------------------------------------------------------------------
// ainb_pkg
// Types and fixed constants of the adaptive impulse noise blanker.
// ----------------------------------------------------------------------------
package ainb_pkg;

    localparam int LEVEL_W         = 25;
    localparam int THR_W           = 16;
    localparam int THR_FRAC_BITS   = 8;
    localparam int ALPHA_W         = 16;
    localparam int ALPHA_FRAC_BITS = 16;
    localparam int ALPHA_ROUND     = (1 << ALPHA_FRAC_BITS) - 1;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_RATIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_ALPHA = 2'd2;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET = 16'd2048;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET     = 16'd1;

    typedef struct packed {
        logic               blank_enable;
        logic [THR_W-1:0]   threshold_ratio;
        logic [ALPHA_W-1:0] smoothing_alpha;
    } cfg_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQUARE,
        F_SUM,
        F_ROOT,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CMP,
        B_UPD
    } back_state_t;

endpackage

>>> hdl/adaptive_impulse_noise_blanker.sv
// ----------------------------------------------------------------------------
// adaptive_impulse_noise_blanker
// Zeroes I/Q samples whose magnitude reaches a multiple of the tracked
// noise level, when blanking is enabled.
// ----------------------------------------------------------------------------
// The front accepts a sample, squares I and Q, sums the squares and takes the
// bit-serial square root, then hands the magnitude to a two-entry queue; it
// takes no new sample until that hand-off is done. The back works through
// the threshold product, the averaging product and the level update,
// overlapped with the front, so the sustained rate is set by the square root;
// a stalled output holds the back. Configuration writes take effect at once
// and belong in idle periods.
module adaptive_impulse_noise_blanker #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int LEVEL_FRAC_BITS = 8,
    localparam int DATA_W         = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [DATA_W-1:0]               s_axis_tdata,  // in_i, in_q
    input  logic                            s_axis_tuser,  // block_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [DATA_W-1:0]               m_axis_tdata,  // out_i, out_q
    output logic                            m_axis_tuser,  // blanked
    input  logic                            cfg_we,
    input  logic [ainb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ainb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ainb_pkg::*;

    localparam int Q_W = 3 * SAMPLE_WIDTH + 1;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic signed [SAMPLE_WIDTH-1:0] in_i;
    logic signed [SAMPLE_WIDTH-1:0] in_q;
    logic signed [SAMPLE_WIDTH-1:0] out_i;
    logic signed [SAMPLE_WIDTH-1:0] out_q;
    logic                           push;
    logic                           full;
    logic [Q_W-1:0]                 push_data;
    logic                           pop;
    logic                           empty;
    logic [Q_W-1:0]                 pop_data;

    assign in_i         = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign in_q         = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    assign m_axis_tdata = DATA_W'({out_q, out_i});

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLANK_ENABLE:    cfg_next.blank_enable    = cfg_data[0];
                CFG_THRESHOLD_RATIO: cfg_next.threshold_ratio = cfg_data[THR_W-1:0];
                CFG_SMOOTHING_ALPHA: cfg_next.smoothing_alpha = cfg_data[ALPHA_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blank_enable    <= 1'b0;
            cfg_reg.threshold_ratio <= THRESHOLD_RESET;
            cfg_reg.smoothing_alpha <= ALPHA_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ainb_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_i        (in_i),
        .in_q        (in_q),
        .block_start (s_axis_tuser),
        .push        (push),
        .full        (full),
        .push_data   (push_data)
    );

    ainb_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (push_data),
        .full    (full),
        .rd_en   (pop),
        .rd_data (pop_data),
        .empty   (empty)
    );

    ainb_back #(
        .SAMPLE_WIDTH    (SAMPLE_WIDTH),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (empty),
        .q_rd_en     (pop),
        .q_data      (pop_data),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_i       (out_i),
        .out_q       (out_q),
        .out_blanked (m_axis_tuser)
    );

endmodule

>>> hdl/ainb_queue.sv
// ----------------------------------------------------------------------------
// ainb_queue
// Small register queue between the magnitude front and the level back.
// ----------------------------------------------------------------------------
module ainb_queue #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/ainb_front.sv
// ----------------------------------------------------------------------------
// ainb_front
// Accepts I/Q samples and finds the magnitude with a bit-serial square root.
// ----------------------------------------------------------------------------
module ainb_front #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] in_i,
    input  logic signed [SAMPLE_WIDTH-1:0] in_q,
    input  logic                      block_start,
    output logic                      push,
    input  logic                      full,
    output logic [3*SAMPLE_WIDTH:0]   push_data
);
    import ainb_pkg::*;

    localparam int SQ_W = 2 * SAMPLE_WIDTH;

    front_state_t state_reg;
    front_state_t state_next;

    logic signed [SAMPLE_WIDTH-1:0] i_reg;
    logic signed [SAMPLE_WIDTH-1:0] q_reg;
    logic                           start_reg;
    logic [SAMPLE_WIDTH-1:0]        abs_i;
    logic [SAMPLE_WIDTH-1:0]        abs_q;
    logic [SAMPLE_WIDTH-1:0]        raw_i;
    logic [SAMPLE_WIDTH-1:0]        raw_q;
    logic [SQ_W-1:0]                sq_i_reg;
    logic [SQ_W-1:0]                sq_q_reg;
    logic [SQ_W-1:0]                x_reg;
    logic [SQ_W-1:0]                root_reg;
    logic [SQ_W-1:0]                bit_reg;
    logic [SQ_W:0]                  trial;
    logic                           fits;

    assign raw_i = i_reg;
    assign raw_q = q_reg;
    assign abs_i = i_reg[SAMPLE_WIDTH-1] ? (~raw_i + 1'b1) : raw_i;
    assign abs_q = q_reg[SAMPLE_WIDTH-1] ? (~raw_q + 1'b1) : raw_q;
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign fits  = ({1'b0, x_reg} >= trial);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_SQUARE;
                end
            end
            F_SQUARE: state_next = F_SUM;
            F_SUM:    state_next = F_ROOT;
            F_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:  state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == F_IDLE);
        push      = (state_reg == F_PUSH) && !full;
        push_data = {start_reg, q_reg, i_reg, root_reg[SAMPLE_WIDTH-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    i_reg     <= in_i;
                    q_reg     <= in_q;
                    start_reg <= block_start;
                end
            end
            F_SQUARE:
            begin
                sq_i_reg <= SQ_W'(abs_i) * SQ_W'(abs_i);
                sq_q_reg <= SQ_W'(abs_q) * SQ_W'(abs_q);
            end
            F_SUM:
            begin
                x_reg    <= sq_i_reg + sq_q_reg;
                root_reg <= '0;
                bit_reg  <= SQ_W'(1) << (SQ_W - 2);
            end
            F_ROOT:
            begin
                if (fits)
                begin
                    x_reg    <= x_reg - trial[SQ_W-1:0];
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> hdl/ainb_back.sv
// ----------------------------------------------------------------------------
// ainb_back
// Threshold test, noise level update and output register.
// ----------------------------------------------------------------------------
module ainb_back #(
    parameter int SAMPLE_WIDTH    = 16,
    parameter int LEVEL_FRAC_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ainb_pkg::cfg_t                 cfg,
    input  logic                           q_empty,
    output logic                           q_rd_en,
    input  logic [3*SAMPLE_WIDTH:0]        q_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_i,
    output logic signed [SAMPLE_WIDTH-1:0] out_q,
    output logic                           out_blanked
);
    import ainb_pkg::*;

    localparam int SW          = SAMPLE_WIDTH;
    localparam int TGT_W       = SW + LEVEL_FRAC_BITS;
    localparam int DIFF_W      = (TGT_W > LEVEL_W) ? TGT_W : LEVEL_W;
    localparam int PROD_W      = THR_W + LEVEL_W;
    localparam int LHS_W       = SW + THR_FRAC_BITS + LEVEL_FRAC_BITS;
    localparam int CMP_W       = (LHS_W > PROD_W) ? LHS_W : PROD_W;
    localparam int STEP_PROD_W = ALPHA_W + DIFF_W;
    localparam int STEP_W      = STEP_PROD_W + 1 - ALPHA_FRAC_BITS;
    localparam int NEXT_W      = STEP_W + 1;
    localparam int LEVEL_INIT_VAL = ((1 << LEVEL_FRAC_BITS) + 5) / 10;
    localparam logic [LEVEL_W-1:0] LEVEL_INIT = LEVEL_W'(LEVEL_INIT_VAL);

    back_state_t state_reg;
    back_state_t state_next;

    logic [LEVEL_W-1:0]     level_reg;
    logic                   out_valid_reg;
    logic [SW-1:0]          mag_reg;
    logic signed [SW-1:0]   i_reg;
    logic signed [SW-1:0]   q_reg;
    logic [LEVEL_W-1:0]     lvl_eff_reg;
    logic [PROD_W-1:0]      thr_prod_reg;
    logic                   pass_reg;
    logic                   neg_reg;
    logic [STEP_PROD_W-1:0] step_prod_reg;
    logic signed [SW-1:0]   out_i_reg;
    logic signed [SW-1:0]   out_q_reg;
    logic                   out_blanked_reg;

    logic [SW-1:0]          pop_mag;
    logic signed [SW-1:0]   pop_i;
    logic signed [SW-1:0]   pop_q;
    logic                   pop_start;
    logic [LEVEL_W-1:0]     lvl_eff;
    logic [PROD_W-1:0]      thr_prod;
    logic [CMP_W-1:0]       lhs;
    logic                   pass;
    logic [DIFF_W-1:0]      tgt;
    logic [DIFF_W-1:0]      lvl_ext;
    logic                   neg;
    logic [DIFF_W-1:0]      dmag;
    logic [STEP_PROD_W-1:0] step_prod;
    logic [STEP_PROD_W:0]   rounded;
    logic [STEP_W-1:0]      step;
    logic [NEXT_W-1:0]      lvl_w;
    logic [NEXT_W-1:0]      step_w;
    logic [NEXT_W-1:0]      sum_w;
    logic [LEVEL_W-1:0]     new_level;
    logic                   blank;
    logic                   done;

    assign pop_mag   = q_data[SW-1:0];
    assign pop_i     = q_data[2*SW-1:SW];
    assign pop_q     = q_data[3*SW-1:2*SW];
    assign pop_start = q_data[3*SW];

    always_comb
    begin
        lvl_eff  = pop_start ? LEVEL_INIT : level_reg;
        thr_prod = PROD_W'(cfg.threshold_ratio) * PROD_W'(lvl_eff);

        lhs     = CMP_W'(mag_reg) << (THR_FRAC_BITS + LEVEL_FRAC_BITS);
        pass    = (lhs < CMP_W'(thr_prod_reg));
        tgt     = DIFF_W'(mag_reg) << LEVEL_FRAC_BITS;
        lvl_ext = DIFF_W'(lvl_eff_reg);
        neg     = (tgt < lvl_ext);
        dmag    = neg ? (lvl_ext - tgt) : (tgt - lvl_ext);
        step_prod = STEP_PROD_W'(cfg.smoothing_alpha) * STEP_PROD_W'(dmag);

        rounded = {1'b0, step_prod_reg}
                + (neg_reg ? (STEP_PROD_W + 1)'(ALPHA_ROUND) : '0);
        step    = rounded[STEP_PROD_W:ALPHA_FRAC_BITS];
        lvl_w   = NEXT_W'(lvl_eff_reg);
        step_w  = NEXT_W'(step);
        sum_w   = lvl_w + step_w;
        if (neg_reg)
        begin
            new_level = (lvl_w < step_w) ? '0 : LEVEL_W'(lvl_w - step_w);
        end
        else
        begin
            new_level = (sum_w > NEXT_W'(LEVEL_MAX)) ? LEVEL_MAX : sum_w[LEVEL_W-1:0];
        end
        blank = !pass_reg && cfg.blank_enable;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_CMP;
                end
            end
            B_CMP:    state_next = B_UPD;
            B_UPD:
            begin
                if (done)
                begin
                    state_next = B_IDLE;
                end
            end
            default:  state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_rd_en     = (state_reg == B_IDLE) && !q_empty;
        done        = (state_reg == B_UPD) && (!out_valid_reg || out_ready);
        out_valid   = out_valid_reg;
        out_i       = out_i_reg;
        out_q       = out_q_reg;
        out_blanked = out_blanked_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            level_reg     <= LEVEL_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                level_reg     <= pass_reg ? new_level : lvl_eff_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd_en)
        begin
            mag_reg      <= pop_mag;
            i_reg        <= pop_i;
            q_reg        <= pop_q;
            lvl_eff_reg  <= lvl_eff;
            thr_prod_reg <= thr_prod;
        end
        if (state_reg == B_CMP)
        begin
            pass_reg      <= pass;
            neg_reg       <= neg;
            step_prod_reg <= step_prod;
        end
        if (done)
        begin
            out_i_reg       <= blank ? '0 : i_reg;
            out_q_reg       <= blank ? '0 : q_reg;
            out_blanked_reg <= blank;
        end
    end

endmodule

>>> hdl/ainb_checker.sv
// ----------------------------------------------------------------------------
// ainb_checker
// Port-level checks of the noise blanker, bound to the top level.
// ----------------------------------------------------------------------------
`include "adaptive_impulse_noise_blanker_defines.svh"

module ainb_checker #(
    parameter int SAMPLE_WIDTH = 16,
    localparam int DATA_W      = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic              m_axis_tuser
);

    `AINB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `AINB_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
    `AINB_ASSERT_NOW(a_blank_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `AINB_ASSERT_NEXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind adaptive_impulse_noise_blanker ainb_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ainb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
